// ===== src/haf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haf_pkg
// Shared constants and types for the Hilbert analytic-signal FIR.
// ----------------------------------------------------------------------------
package haf_pkg;

   // Filter length, clamped into 3..31 and rounded up to an odd count.
   localparam int NUM_TAPS   = 31;
   localparam int TAPS_CLAMP = (NUM_TAPS < 3) ? 3 : ((NUM_TAPS > 31) ? 31 : NUM_TAPS);
   localparam int TAPS_LEN   = ((TAPS_CLAMP % 2) == 0) ? TAPS_CLAMP + 1 : TAPS_CLAMP;
   localparam int MID        = (TAPS_LEN - 1) / 2;

   // Odd offsets 1, 3, .. up to MID; one MAC cell each.
   localparam int NUM_USED   = (MID + 1) / 2;
   // Oldest tap read is MID plus the largest odd offset.
   localparam int DEPTH      = MID + 2 * NUM_USED - 1;

   localparam int NUM_COEF   = 8;
   localparam int CSR_IDX_W  = $clog2(NUM_COEF);

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 15;
   localparam int DIFF_W     = SAMPLE_W + 1;
   localparam int PROD_W     = COEF_W + 1 + DIFF_W;
   localparam int ACC_W      = PROD_W + $clog2(NUM_COEF);
   localparam int FRAC_W     = 15;
   localparam int IMAG_W     = 18;

   localparam logic [COEF_W-1:0] COEF_RESET [NUM_COEF] = '{
      15'd20651, 15'd6343, 15'd3213, 15'd1753, 15'd922, 15'd440, 15'd192, 15'd111
   };

   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef diff_type [NUM_USED-1:0] diff_vec_type;

   // One request in flight along the MAC chain.
   typedef struct packed {
      logic                       valid;
      logic signed [ACC_W-1:0]    acc;
      logic signed [SAMPLE_W-1:0] re;
      diff_vec_type               diffs;
   } stage_type;

endpackage

// ===== src/haf_delay_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haf_delay_cell
// One sample of the delay line; loads its neighbor's sample on a shift.
// ----------------------------------------------------------------------------
module haf_delay_cell import haf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       shift_en,
   input  logic signed [SAMPLE_W-1:0] d_in,
   output logic signed [SAMPLE_W-1:0] q_out
);

   logic signed [SAMPLE_W-1:0] q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else if (shift_en) begin
         q_ff <= d_in;
      end
   end

   assign q_out = q_ff;

endmodule

// ===== src/haf_mac_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haf_mac_cell
// One systolic MAC step: add coef times the lowest difference, drop it.
// ----------------------------------------------------------------------------
module haf_mac_cell import haf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [COEF_W-1:0] coef,
   input  stage_type         stage_in,
   output logic              in_ready,
   output stage_type         stage_out,
   input  logic              out_ready
);

   logic                       valid_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_in;
   logic signed [SAMPLE_W-1:0] re_ff;
   diff_vec_type               diffs_ff;
   diff_vec_type               diffs_in;
   diff_type                   diff_cur;
   logic signed [PROD_W-1:0]   prod;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      diff_cur = stage_in.diffs[0];
      prod     = $signed({1'b0, coef}) * diff_cur;
      acc_in   = stage_in.acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
      // drop the difference used here, advance the rest
      diffs_in = diff_vec_type'(stage_in.diffs >> DIFF_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && stage_in.valid) begin
         acc_ff   <= acc_in;
         re_ff    <= stage_in.re;
         diffs_ff <= diffs_in;
      end
   end

   assign stage_out = '{valid: valid_ff, acc: acc_ff, re: re_ff, diffs: diffs_ff};

endmodule

// ===== src/hilbert_analytic_fir.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hilbert_analytic_fir
// Analytic-signal generator: delayed real part and Hilbert FIR imaginary part.
// ----------------------------------------------------------------------------
// Takes one request per clock while req_ready is high and returns one (real,
// imag) pair per request, in order. A request moves through the delay line
// into a chain of single-multiplier MAC cells, one per odd tap offset (eight
// for the 31-tap filter), then through a round-and-saturate output register.
// Each cell stalls only when it holds a request its neighbor cannot take, so
// new requests can still enter empty cells while a result waits at the output.
// The real part is the sample delayed by the filter center; the imaginary part
// is sum(coef_d * (x[k-M-d] - x[k-M+d])) over odd d, rounded half up, shifted
// right by 15 and saturated to 18 bits. Coefficients are 15-bit Q15 registers
// written through the csr port; the user must write them only while the block
// is idle, which the block does not enforce. Reset loads the designed
// Hamming-windowed taps and clears the delay line.
// ----------------------------------------------------------------------------
module hilbert_analytic_fir import haf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_real_part,
   output logic signed [IMAG_W-1:0]   rsp_imag_part,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [COEF_W-1:0]          csr_wdata
);

   localparam int QUO_W = ACC_W - FRAC_W;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);

   logic [COEF_W-1:0]          coef_ff [NUM_COEF];
   logic signed [SAMPLE_W-1:0] delay_q [DEPTH];
   logic signed [SAMPLE_W-1:0] tap     [DEPTH + 1];
   diff_vec_type               diffs_new;
   stage_type                  stage   [NUM_USED + 1];
   logic                       ready   [NUM_USED + 1];
   logic                       req_accept;

   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_real_ff;
   logic signed [IMAG_W-1:0]   rsp_imag_ff;
   logic signed [IMAG_W-1:0]   imag_in;
   logic signed [ACC_W-1:0]    rounded;
   logic signed [QUO_W-1:0]    quo;

   // Coefficient registers; write only while idle (the block does not check).
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
      end else if (csr_we) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   assign req_ready  = ready[0];
   assign req_accept = req_valid && req_ready;

   // Delay line: cell i holds x[k-1-i]; shift on every accepted request.
   for (genvar i = 0; i < DEPTH; i++) begin : g_delay
      haf_delay_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (req_accept),
         .d_in     (tap[i]),
         .q_out    (delay_q[i])
      );
   end

   // Tap 0 is the incoming sample, tap t the delay cell t-1.
   assign tap[0] = req_sample_in;
   for (genvar t = 1; t <= DEPTH; t++) begin : g_tap
      assign tap[t] = delay_q[t-1];
   end

   // Odd-symmetric differences, one per odd offset, taken at accept time.
   for (genvar j = 0; j < NUM_USED; j++) begin : g_diff
      localparam int HI = MID + 2 * j + 1;
      localparam int LO = MID - 2 * j - 1;
      assign diffs_new[j] = {tap[HI][SAMPLE_W-1], tap[HI]} - {tap[LO][SAMPLE_W-1], tap[LO]};
   end

   assign stage[0] = '{valid: req_valid, acc: '0, re: tap[MID], diffs: diffs_new};

   // MAC chain: cell j accumulates the offset 2j+1 term.
   for (genvar j = 0; j < NUM_USED; j++) begin : g_mac
      haf_mac_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .coef      (coef_ff[j]),
         .stage_in  (stage[j]),
         .in_ready  (ready[j]),
         .stage_out (stage[j+1]),
         .out_ready (ready[j+1])
      );
   end

   // Round half up, floor-shift by the Q15 scale, saturate to 18 bits.
   always_comb begin
      rounded = stage[NUM_USED].acc + ROUND_HALF;
      quo     = $signed(rounded[ACC_W-1:FRAC_W]);
      if (quo[QUO_W-1:IMAG_W-1] == '0 || quo[QUO_W-1:IMAG_W-1] == '1) begin
         imag_in = quo[IMAG_W-1:0];
      end else if (quo[QUO_W-1]) begin
         imag_in = {1'b1, {(IMAG_W - 1){1'b0}}};
      end else begin
         imag_in = {1'b0, {(IMAG_W - 1){1'b1}}};
      end
   end

   // Output register: take a new result whenever the slot is free or drains.
   assign ready[NUM_USED] = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready[NUM_USED]) begin
         rsp_valid_ff <= stage[NUM_USED].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[NUM_USED] && stage[NUM_USED].valid) begin
         rsp_real_ff <= stage[NUM_USED].re;
         rsp_imag_ff <= imag_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_real_part = rsp_real_ff;
   assign rsp_imag_part = rsp_imag_ff;

   // Input stalls only behind a request held in the first MAC cell.
   a_ready_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> stage[1].valid)
      else $error("request stalled while first cell empty");

   // Accepted sample lands in the newest delay cell.
   a_delay_load : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> delay_q[0] == $past(req_sample_in))
      else $error("delay line did not load accepted sample");

   // Oldest delay cell holds when no request is accepted.
   a_delay_hold : assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(delay_q[DEPTH-1]))
      else $error("delay line moved without a request");

   // A result held at the output keeps the chain's last cell from draining.
   a_chain_stall : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && stage[NUM_USED].valid) |=> stage[NUM_USED].valid)
      else $error("last cell dropped a request while output stalled");

endmodule
